### rtl/core/gpio_port_with_pin_config_top_macros.svh
// Assertion macros shared by the GPIO port checker.
`ifndef GPIO_PORT_WITH_PIN_CONFIG_TOP_MACROS_SVH
`define GPIO_PORT_WITH_PIN_CONFIG_TOP_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define GPIOPC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define GPIOPC_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/gpiopc_pkg.sv
// Package with types, codes and constants of the GPIO port controller.
package gpiopc_pkg;

	// Default number of implemented pins.
	localparam int PinCountDefault = 32;

	// Bit positions inside a per-pin configuration word.
	localparam int CfgInputBit   = 1;
	localparam int CfgPullOffBit = 2;

	// Drive level code of a pin event that releases the pin.
	localparam logic [1:0] DriveRelease = 2'd2;

	// Kind of an input word.
	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_EVENT = 2'd2
	} opcode_t;

	// Register selector codes.
	typedef enum logic [3:0] {
		SEL_OUT      = 4'd0,
		SEL_OUTCLR   = 4'd1,
		SEL_OUTSET   = 4'd2,
		SEL_OUTTGL   = 4'd3,
		SEL_DIR      = 4'd4,
		SEL_DIRCLR   = 4'd5,
		SEL_DIRSET   = 4'd6,
		SEL_DIRTGL   = 4'd7,
		SEL_IN       = 4'd8,
		SEL_CONTROL  = 4'd9,
		SEL_WRCONFIG = 4'd10,
		SEL_PMUX     = 4'd11,
		SEL_PINCFG   = 4'd12
	} sel_t;

	// One input word, unpacked into its fields.
	typedef struct packed {
		logic [1:0]  opcode;
		logic [3:0]  reg_sel;
		logic [4:0]  pin_index;
		logic [31:0] write_data;
		logic [1:0]  pin_drive;
	} item_t;

	// One result word.
	typedef struct packed {
		logic [31:0] read_data;
		logic        bad_offset;
		logic [31:0] pin_level;
		logic [31:0] pin_driven;
		logic [31:0] pin_changed;
	} result_t;

endpackage

### rtl/core/gpiopc_in_stage.sv
// Input register stage that holds one accepted word for the engine.
module gpiopc_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  gpiopc_pkg::item_t   in_item,
	input  logic                advance,
	output logic                valid_s1,
	output gpiopc_pkg::item_t   item_s1
);

	// The stage takes a new word when empty or when its word moves on.
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload needs no reset.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

### rtl/core/gpiopc_engine.sv
// Port state registers and the single-pass update of all pins for one word.
module gpiopc_engine #(
	parameter int PIN_COUNT = gpiopc_pkg::PinCountDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  gpiopc_pkg::item_t   item,
	output gpiopc_pkg::result_t result
);

	localparam logic [31:0] PinMask = 32'((64'd1 << PIN_COUNT) - 64'd1);

	logic [31:0] out_q, dir_q, in_q, ext_q, lvl_q, drv_q;
	logic [31:0] out_d, dir_d, in_d, ext_d, lvl_d, drv_d;
	logic [31:0] cfg_q [PIN_COUNT];
	logic [31:0] cfg_d [PIN_COUNT];

	logic [31:0] rd, chg, inp, pull, forced, pbit;
	logic        bad, pin_ok, dir_wr;

	// Next state and result for the word in the input register.
	always_comb begin
		out_d  = out_q;
		dir_d  = dir_q;
		in_d   = in_q;
		ext_d  = ext_q;
		lvl_d  = lvl_q;
		drv_d  = drv_q;
		cfg_d  = cfg_q;
		rd     = '0;
		chg    = '0;
		inp    = '0;
		pull   = '0;
		forced = '0;
		bad    = 1'b0;
		dir_wr = 1'b0;
		pin_ok = 6'(item.pin_index) < 6'(PIN_COUNT);
		pbit   = 32'd1 << item.pin_index;

		case (item.opcode)
			gpiopc_pkg::OP_READ: begin
				case (item.reg_sel)
					gpiopc_pkg::SEL_OUT, gpiopc_pkg::SEL_OUTCLR: rd = out_q;
					gpiopc_pkg::SEL_DIR, gpiopc_pkg::SEL_DIRCLR: rd = dir_q;
					gpiopc_pkg::SEL_IN: rd = in_q;
					gpiopc_pkg::SEL_CONTROL, gpiopc_pkg::SEL_WRCONFIG: rd = '0;
					gpiopc_pkg::SEL_PINCFG: begin
						for (int p = 0; p < PIN_COUNT; p++) begin
							if (item.pin_index == 5'(p)) begin
								rd = cfg_q[p];
							end
						end
					end
					default: bad = 1'b1;
				endcase
			end
			gpiopc_pkg::OP_WRITE: begin
				case (item.reg_sel)
					gpiopc_pkg::SEL_OUT:    out_d = item.write_data;
					gpiopc_pkg::SEL_OUTSET: out_d = out_q | item.write_data;
					gpiopc_pkg::SEL_OUTCLR: out_d = out_q & ~item.write_data;
					gpiopc_pkg::SEL_OUTTGL: out_d = out_q ^ item.write_data;
					gpiopc_pkg::SEL_DIR: begin
						dir_d  = item.write_data;
						dir_wr = 1'b1;
					end
					gpiopc_pkg::SEL_DIRSET: begin
						dir_d  = dir_q | item.write_data;
						dir_wr = 1'b1;
					end
					gpiopc_pkg::SEL_DIRCLR: begin
						dir_d  = dir_q & ~item.write_data;
						dir_wr = 1'b1;
					end
					gpiopc_pkg::SEL_DIRTGL: begin
						dir_d  = dir_q ^ item.write_data;
						dir_wr = 1'b1;
					end
					gpiopc_pkg::SEL_CONTROL, gpiopc_pkg::SEL_WRCONFIG,
					gpiopc_pkg::SEL_PMUX: ;
					gpiopc_pkg::SEL_PINCFG: begin
						// A config write also updates the one matching direction bit.
						if (pin_ok) begin
							for (int p = 0; p < PIN_COUNT; p++) begin
								if (item.pin_index == 5'(p)) begin
									cfg_d[p] = item.write_data;
								end
							end
							dir_d = item.write_data[gpiopc_pkg::CfgInputBit] ?
								(dir_q & ~pbit) : (dir_q | pbit);
						end
					end
					default: bad = 1'b1;
				endcase

				// Direction writes are mirrored into the input-mode bit of every pin.
				if (dir_wr) begin
					for (int p = 0; p < PIN_COUNT; p++) begin
						cfg_d[p][gpiopc_pkg::CfgInputBit] = ~dir_d[p];
					end
				end

				// Re-evaluate every pin from the updated configuration.
				for (int p = 0; p < PIN_COUNT; p++) begin
					inp[p]  = cfg_d[p][gpiopc_pkg::CfgInputBit];
					pull[p] = ~cfg_d[p][gpiopc_pkg::CfgPullOffBit];
				end
				forced = inp & ext_q & pull;
				drv_d  = (~inp | forced) & PinMask;
				lvl_d  = (out_d | forced) & PinMask;
				in_d   = in_q | (pull & (~inp | ext_q) & PinMask);
				chg    = ((drv_d ^ drv_q) | (lvl_d ^ lvl_q)) & PinMask;
			end
			gpiopc_pkg::OP_EVENT: begin
				// An external level connects the pin; release or any other code disconnects it.
				if (pin_ok) begin
					if (item.pin_drive < gpiopc_pkg::DriveRelease) begin
						ext_d = ext_q | pbit;
						in_d  = item.pin_drive[0] ? (in_q | pbit) : (in_q & ~pbit);
					end else begin
						ext_d = ext_q & ~pbit;
					end
				end
			end
			default: ;
		endcase
	end

	assign result.read_data   = rd;
	assign result.bad_offset  = bad;
	assign result.pin_level   = lvl_d;
	assign result.pin_driven  = drv_d;
	assign result.pin_changed = chg;

	// State commits when the word's result is loaded into the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
			dir_q <= '0;
			in_q  <= '0;
			ext_q <= '0;
			lvl_q <= '0;
			drv_q <= '0;
			for (int p = 0; p < PIN_COUNT; p++) begin
				cfg_q[p] <= '0;
			end
		end else if (fire) begin
			out_q <= out_d;
			dir_q <= dir_d;
			in_q  <= in_d;
			ext_q <= ext_d;
			lvl_q <= lvl_d;
			drv_q <= drv_d;
			cfg_q <= cfg_d;
		end
	end

endmodule

### rtl/core/gpiopc_out_stage.sv
// Result register that holds one word until the downstream side takes it.
module gpiopc_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  gpiopc_pkg::result_t result,
	output logic                free,
	output logic                out_valid,
	input  logic                out_ready,
	output gpiopc_pkg::result_t out_result
);

	// The register can load when empty or when its word leaves this cycle.
	assign free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_result <= result;
		end
	end

endmodule

### rtl/core/gpio_port_with_pin_config_top.sv
// Top level of the 32-pin GPIO port controller with per-pin configuration.
//
//   Channel | Direction | Word contents
//   s_*     | in        | register read, register write or external pin event
//   m_*     | out       | read value, offset error flag and pin state, one per input word
//
// One word is accepted per cycle while the output side does not stall; it is held in the input
// register, and its result is then loaded into the output register, which raises m_tvalid.
// The rate is set by the single update of the port state from the input register
// into the result register, which is combinational for any word.
// Reset clears all port registers, the pin configuration words and both valid flags.
// With m_tready low the result is held and one more word waits in the input register,
// after which s_tready falls.
module gpio_port_with_pin_config_top #(
	parameter int PIN_COUNT = gpiopc_pkg::PinCountDefault
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [39:0]  s_tdata,  // pin_index[4:0], write_data[36:5], pin_drive[38:37], zero pad
	input  logic [5:0]   s_tuser,  // opcode[1:0], reg_sel[5:2]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,  // read_data, pin_level, pin_driven, pin_changed
	output logic         m_tuser   // bad_offset
);

	gpiopc_pkg::item_t   in_item, item_s1;
	gpiopc_pkg::result_t result, out_result;
	logic                valid_s1, out_free, fire;

	// Unpack the input word into its fields.
	assign in_item.opcode     = s_tuser[1:0];
	assign in_item.reg_sel    = s_tuser[5:2];
	assign in_item.pin_index  = s_tdata[4:0];
	assign in_item.write_data = s_tdata[36:5];
	assign in_item.pin_drive  = s_tdata[38:37];

	// A word is processed when the result register can take its result.
	assign fire = valid_s1 && out_free;

	gpiopc_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.advance  (fire),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	gpiopc_engine #(
		.PIN_COUNT (PIN_COUNT)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.result (result)
	);

	gpiopc_out_stage u_out_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (fire),
		.result     (result),
		.free       (out_free),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (out_result)
	);

	// Pack the result word.
	assign m_tdata = {out_result.pin_changed, out_result.pin_driven,
		out_result.pin_level, out_result.read_data};
	assign m_tuser = out_result.bad_offset;

endmodule

### rtl/core/gpiopc_checker.sv
// Port-level checks of the GPIO port controller and their binding to the top level.
`include "gpio_port_with_pin_config_top_macros.svh"

module gpiopc_checker #(
	parameter int PIN_COUNT = gpiopc_pkg::PinCountDefault
) (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata,
	input logic         m_tuser
);

	localparam logic [31:0] PinMask = 32'((64'd1 << PIN_COUNT) - 64'd1);

	logic [31:0] stray_pins;

	// Level, drive and change bits that fall on unimplemented pins.
	assign stray_pins = (m_tdata[63:32] | m_tdata[95:64] | m_tdata[127:96]) & ~PinMask;

	// A word that has not been taken stays offered.
	`GPIOPC_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")

	// Unimplemented pins never show level, drive or change.
	`GPIOPC_ASSERT(a_pin_range, m_tvalid |-> stray_pins == 32'd0, "state on unimplemented pin")

	// A rejected offset never returns read data.
	`GPIOPC_ASSERT(a_bad_zero, m_tvalid && m_tuser |-> m_tdata[31:0] == 32'd0, "read data with offset error")

	// No result is offered while reset is asserted.
	`GPIOPC_ASSERT_RST(a_rst_idle, !arst_n |-> !m_tvalid, "result valid in reset")

	// An unaccepted input word keeps s_tready low only while a result waits.
	`GPIOPC_ASSERT(a_ready_stall, !s_tready |-> m_tvalid, "input stalled with empty output")

endmodule

bind gpio_port_with_pin_config_top gpiopc_checker #(
	.PIN_COUNT (PIN_COUNT)
) u_gpiopc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

### test/tb.sv
// Self-checking testbench for the 32-pin GPIO port controller with per-pin configuration.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          PinCount    = gpiopc_pkg::PinCountDefault;
	localparam logic [1:0]  OpUnused    = 2'd3;
	localparam logic [3:0]  SelBadFirst = 4'd13;
	localparam logic [3:0]  SelBadLast  = 4'd15;
	localparam logic [1:0]  DriveLow    = 2'd0;
	localparam logic [1:0]  DriveHigh   = 2'd1;
	localparam logic [1:0]  DriveUnused = 2'd3;
	localparam int          CycleLimit  = 300000;
	localparam int          DrainCycles = 8;
	localparam int          RandomWords = 850;
	localparam int          HoldAfter   = 150;
	localparam int          HoldCycles  = 300;

	// Shadow copy of the port state that predicts every result word.
	class port_shadow;
		logic [31:0]         out_q, in_q, ext_q, dir_q, level_q, driven_q;
		logic [31:0]         cfg [32];
		gpiopc_pkg::result_t expected_words [$];
		int                  mismatches;

		function new();
			out_q = '0;
			in_q = '0;
			ext_q = '0;
			dir_q = '0;
			level_q = '0;
			driven_q = '0;
			foreach (cfg[p]) cfg[p] = '0;
			mismatches = 0;
		endfunction

		// Apply one accepted input word and queue the result it must produce.
		function void note_word(gpiopc_pkg::item_t w);
			logic [31:0]         rd, changed, pin_bit, inp, pull, forced, drv, lvl, m;
			logic                bad, pin_ok, mirror;
			gpiopc_pkg::result_t r;
			rd = '0;
			bad = 1'b0;
			changed = '0;
			mirror = 1'b0;
			m = (PinCount >= 32) ? '1 : ((32'd1 << PinCount) - 32'd1);
			pin_ok = int'(w.pin_index) < PinCount;
			pin_bit = 32'd1 << w.pin_index;
			case (w.opcode)
				gpiopc_pkg::OP_READ: begin
					case (w.reg_sel)
						gpiopc_pkg::SEL_OUT, gpiopc_pkg::SEL_OUTCLR: rd = out_q;
						gpiopc_pkg::SEL_DIR, gpiopc_pkg::SEL_DIRCLR: rd = dir_q;
						gpiopc_pkg::SEL_IN: rd = in_q;
						gpiopc_pkg::SEL_CONTROL, gpiopc_pkg::SEL_WRCONFIG: rd = '0;
						gpiopc_pkg::SEL_PINCFG: rd = pin_ok ? cfg[w.pin_index] : '0;
						default: bad = 1'b1;
					endcase
				end
				gpiopc_pkg::OP_WRITE: begin
					case (w.reg_sel)
						gpiopc_pkg::SEL_OUT:    out_q = w.write_data;
						gpiopc_pkg::SEL_OUTSET: out_q = out_q | w.write_data;
						gpiopc_pkg::SEL_OUTCLR: out_q = out_q & ~w.write_data;
						gpiopc_pkg::SEL_OUTTGL: out_q = out_q ^ w.write_data;
						gpiopc_pkg::SEL_DIR: begin
							dir_q = w.write_data;
							mirror = 1'b1;
						end
						gpiopc_pkg::SEL_DIRSET: begin
							dir_q = dir_q | w.write_data;
							mirror = 1'b1;
						end
						gpiopc_pkg::SEL_DIRCLR: begin
							dir_q = dir_q & ~w.write_data;
							mirror = 1'b1;
						end
						gpiopc_pkg::SEL_DIRTGL: begin
							dir_q = dir_q ^ w.write_data;
							mirror = 1'b1;
						end
						gpiopc_pkg::SEL_CONTROL, gpiopc_pkg::SEL_WRCONFIG,
						gpiopc_pkg::SEL_PMUX: ;
						gpiopc_pkg::SEL_PINCFG: begin
							// A config write also updates the one matching direction bit.
							if (pin_ok) begin
								cfg[w.pin_index] = w.write_data;
								dir_q[w.pin_index] = ~w.write_data[gpiopc_pkg::CfgInputBit];
							end
						end
						default: bad = 1'b1;
					endcase
					// Direction bit 1 means output, config input bit 1 means input.
					if (mirror) begin
						for (int p = 0; p < PinCount; p++) begin
							cfg[p][gpiopc_pkg::CfgInputBit] = ~dir_q[p];
						end
					end
					// Every write re-evaluates all pins at once.
					inp = '0;
					pull = '0;
					for (int p = 0; p < PinCount; p++) begin
						inp[p] = cfg[p][gpiopc_pkg::CfgInputBit];
						pull[p] = ~cfg[p][gpiopc_pkg::CfgPullOffBit];
					end
					forced = inp & ext_q & pull;
					drv = (~inp | forced) & m;
					lvl = (out_q | forced) & m;
					in_q = in_q | (pull & (~inp | ext_q) & m);
					changed = ((drv ^ driven_q) | (lvl ^ level_q)) & m;
					driven_q = (driven_q & ~m) | drv;
					level_q = (level_q & ~m) | lvl;
				end
				gpiopc_pkg::OP_EVENT: begin
					// Low or high connects the pin and sets IN to that level; anything else releases it.
					if (pin_ok) begin
						if (w.pin_drive <= DriveHigh) begin
							ext_q = ext_q | pin_bit;
							in_q = (in_q & ~pin_bit) | (w.pin_drive == DriveHigh ? pin_bit : '0);
						end else begin
							ext_q = ext_q & ~pin_bit;
						end
					end
				end
				default: ;
			endcase
			r.read_data = rd;
			r.bad_offset = bad;
			r.pin_level = level_q;
			r.pin_driven = driven_q;
			r.pin_changed = changed;
			expected_words.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
			if (exp_v !== act_v) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v,
					act_v);
				mismatches++;
			end
		endfunction

		// Compare one result word with the oldest prediction.
		function void check_word(gpiopc_pkg::result_t got);
			gpiopc_pkg::result_t exp_w;
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected result word, expected none, actual %h", $realtime,
					got);
				mismatches++;
				return;
			end
			exp_w = expected_words.pop_front();
			compare_field("read_data", exp_w.read_data, got.read_data);
			compare_field("bad_offset", 32'(exp_w.bad_offset), 32'(got.bad_offset));
			compare_field("pin_level", exp_w.pin_level, got.pin_level);
			compare_field("pin_driven", exp_w.pin_driven, got.pin_driven);
			compare_field("pin_changed", exp_w.pin_changed, got.pin_changed);
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b1;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [39:0]  s_tdata = '0;
	logic [5:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;
	logic         m_tuser;

	port_shadow   shadow;
	int           send_idle = 27;
	int           recv_idle = 70;
	int           results_seen = 0;
	int           hold_left = 0;
	int           cycles = 0;

	gpio_port_with_pin_config_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic gpiopc_pkg::item_t mk(logic [1:0] op, logic [3:0] sel, logic [4:0] pin,
		logic [31:0] data, logic [1:0] drv);
		gpiopc_pkg::item_t w;
		w.opcode = op;
		w.reg_sel = sel;
		w.pin_index = pin;
		w.write_data = data;
		w.pin_drive = drv;
		return w;
	endfunction

	// Mostly valid accesses and pin events, with some invalid selectors and unused opcodes.
	function automatic gpiopc_pkg::item_t random_word();
		gpiopc_pkg::item_t w;
		int unsigned       k;
		k = $urandom_range(99);
		if (k < 30) w.opcode = gpiopc_pkg::OP_READ;
		else if (k < 75) w.opcode = gpiopc_pkg::OP_WRITE;
		else if (k < 95) w.opcode = gpiopc_pkg::OP_EVENT;
		else w.opcode = OpUnused;
		k = $urandom_range(99);
		if (k < 8) w.reg_sel = 4'($urandom_range(SelBadLast, SelBadFirst));
		else if (k < 30) w.reg_sel = gpiopc_pkg::SEL_PINCFG;
		else w.reg_sel = 4'($urandom_range(gpiopc_pkg::SEL_PINCFG));
		w.pin_index = 5'($urandom);
		k = $urandom_range(9);
		if (k == 0) w.write_data = '0;
		else if (k == 1) w.write_data = '1;
		else if (k == 2) w.write_data = 32'd1 << $urandom_range(31);
		else w.write_data = $urandom;
		w.pin_drive = 2'($urandom);
		return w;
	endfunction

	// Offer one word, with random idle cycles first, and hold it until accepted.
	task automatic send_word(input gpiopc_pkg::item_t w);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, w.pin_drive, w.write_data, w.pin_index};
		s_tuser <= {w.reg_sel, w.opcode};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		shadow.note_word(w);
	endtask

	// Result side: check accepted words, stall at random, and hold off once for a long stretch.
	initial begin
		gpiopc_pkg::result_t got;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got.read_data = m_tdata[31:0];
				got.pin_level = m_tdata[63:32];
				got.pin_driven = m_tdata[95:64];
				got.pin_changed = m_tdata[127:96];
				got.bad_offset = m_tuser;
				shadow.check_word(got);
				results_seen++;
				if (results_seen == HoldAfter) hold_left = HoldCycles;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// Watchdog on the whole run.
	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CycleLimit) begin
				$display("tb: errors");
				$finish;
			end
		end
	end

	initial begin
		// Reset goes active at time zero, after every process waits on its clock.
		arst_n <= 1'b0;
		shadow = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words: reset values, every write form, pull-up with a driven pin, bad offsets.
		send_word(mk(gpiopc_pkg::OP_READ, gpiopc_pkg::SEL_OUT, 5'd0, '0, DriveLow));
		send_word(mk(gpiopc_pkg::OP_WRITE, gpiopc_pkg::SEL_OUT, 5'd0, '1, DriveLow));
		send_word(mk(gpiopc_pkg::OP_WRITE, gpiopc_pkg::SEL_DIR, 5'd0, '1, DriveLow));
		send_word(mk(gpiopc_pkg::OP_WRITE, gpiopc_pkg::SEL_OUTCLR, 5'd0, 32'h0000_FFFF,
			DriveLow));
		send_word(mk(gpiopc_pkg::OP_WRITE, gpiopc_pkg::SEL_OUTSET, 5'd0, 32'h0000_0001,
			DriveLow));
		send_word(mk(gpiopc_pkg::OP_WRITE, gpiopc_pkg::SEL_OUTTGL, 5'd0, '1, DriveLow));
		send_word(mk(gpiopc_pkg::OP_WRITE, gpiopc_pkg::SEL_DIRCLR, 5'd0, 32'hF0F0_F0F0,
			DriveLow));
		send_word(mk(gpiopc_pkg::OP_WRITE, gpiopc_pkg::SEL_DIRSET, 5'd0, 32'h0000_0001,
			DriveLow));
		send_word(mk(gpiopc_pkg::OP_WRITE, gpiopc_pkg::SEL_DIRTGL, 5'd0, '1, DriveLow));
		send_word(mk(gpiopc_pkg::OP_WRITE, gpiopc_pkg::SEL_PINCFG, 5'd31, '1, DriveLow));
		send_word(mk(gpiopc_pkg::OP_WRITE, gpiopc_pkg::SEL_PINCFG, 5'd0, 32'h0000_0002,
			DriveLow));
		send_word(mk(gpiopc_pkg::OP_EVENT, gpiopc_pkg::SEL_OUT, 5'd0, '0, DriveHigh));
		send_word(mk(gpiopc_pkg::OP_WRITE, gpiopc_pkg::SEL_CONTROL, 5'd0, '1, DriveLow));
		send_word(mk(gpiopc_pkg::OP_EVENT, gpiopc_pkg::SEL_OUT, 5'd0, '0, DriveLow));
		send_word(mk(gpiopc_pkg::OP_EVENT, gpiopc_pkg::SEL_OUT, 5'd0, '0, DriveUnused));
		send_word(mk(gpiopc_pkg::OP_EVENT, gpiopc_pkg::SEL_OUT, 5'd5, '0,
			gpiopc_pkg::DriveRelease));
		send_word(mk(gpiopc_pkg::OP_WRITE, gpiopc_pkg::SEL_PMUX, 5'd0, '1, DriveLow));
		send_word(mk(gpiopc_pkg::OP_WRITE, gpiopc_pkg::SEL_IN, 5'd0, '1, DriveLow));
		send_word(mk(gpiopc_pkg::OP_WRITE, SelBadLast, 5'd0, '1, DriveLow));
		send_word(mk(gpiopc_pkg::OP_READ, gpiopc_pkg::SEL_IN, 5'd0, '0, DriveLow));
		send_word(mk(gpiopc_pkg::OP_READ, gpiopc_pkg::SEL_PINCFG, 5'd31, '0, DriveLow));
		send_word(mk(gpiopc_pkg::OP_READ, gpiopc_pkg::SEL_DIRCLR, 5'd0, '0, DriveLow));
		send_word(mk(gpiopc_pkg::OP_READ, gpiopc_pkg::SEL_OUTSET, 5'd0, '0, DriveLow));
		send_word(mk(gpiopc_pkg::OP_READ, SelBadFirst, 5'd0, '0, DriveLow));
		send_word(mk(gpiopc_pkg::OP_READ, gpiopc_pkg::SEL_WRCONFIG, 5'd0, '0, DriveLow));
		send_word(mk(OpUnused, gpiopc_pkg::SEL_OUT, 5'd0, '1, DriveHigh));

		// Random words in three idling phases.
		for (int i = 0; i < RandomWords; i++) begin
			if (i == RandomWords / 3) begin
				send_idle = 70;
				recv_idle = 27;
			end
			if (i == 2 * RandomWords / 3) begin
				send_idle = 0;
				recv_idle = 0;
			end
			send_word(random_word());
		end
		s_tvalid <= 1'b0;

		// Drain the remaining results, then allow for the pipeline latency.
		while (shadow.expected_words.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (shadow.mismatches == 0 && shadow.expected_words.size() == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end
endmodule

### files.f
+incdir+rtl/core
rtl/core/gpiopc_pkg.sv
rtl/core/gpiopc_in_stage.sv
rtl/core/gpiopc_engine.sv
rtl/core/gpiopc_out_stage.sv
rtl/core/gpio_port_with_pin_config_top.sv
rtl/core/gpiopc_checker.sv
test/tb.sv
